// ===== src/wcd_pkg.sv =====
// Shared widths, defaults and codes for the wait-cycle deadlock detector.
package wcd_pkg;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 3;
  localparam int WL_W     = 8;
  localparam int EU_W     = 7;

  localparam int DEF_MAX_AGENTS = 64;
  localparam int DEF_ID_BITS    = 16;
  localparam int DEF_LEVEL_BITS = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_WORK_BEGIN = 2'd0,
    CMD_WORK_END   = 2'd1,
    CMD_WAIT_BEGIN = 2'd2,
    CMD_WAIT_END   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_CYCLE    = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOWORK   = 3'd3,
    ST_WAITMIS  = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

endpackage

// ===== src/wcd_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module wcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/wait_cycle_deadlock_detector.sv =====
// Top level of the wait-cycle deadlock detector: agent table, scan sequencer, result register.
//
// Usage:
//   Input channel (in_valid / in_stall): one request per event, in_cmd gives the kind
//   (work begins, work ends, wait begins, wait ends), in_agent_id names the agent.
//   Result channel (out_valid / out_stall): one result per request with out_status,
//   the agent's out_work_level and out_entries_used after the event.
//   The agent table lives in one RAM. Each request scans every table entry through the
//   single read port, one entry per cycle, for the agent lookup, the lowest free entry
//   and the active-agent check, then writes the updated entry back.
//   A request passes from S_IDLE through S_SCAN to S_EXEC, which writes the entry back and
//   fills the result register; in_stall stays high outside S_IDLE, so a new request is
//   taken only once the previous one has left S_EXEC.
//   After reset the table RAM is cleared one entry per cycle, with in_stall high. A
//   finished result sits in the output register while out_stall is high; the next
//   request is still accepted and scanned, and it only waits for its write-back until
//   the pending result has been taken.
module wait_cycle_deadlock_detector #(
  parameter int MAX_AGENTS = wcd_pkg::DEF_MAX_AGENTS,
  parameter int ID_BITS    = wcd_pkg::DEF_ID_BITS,
  parameter int LEVEL_BITS = wcd_pkg::DEF_LEVEL_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wcd_pkg::CMD_W-1:0]     in_cmd,
  input  logic [wcd_pkg::ID_W-1:0]      in_agent_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wcd_pkg::STATUS_W-1:0]  out_status,
  output logic [wcd_pkg::WL_W-1:0]      out_work_level,
  output logic [wcd_pkg::EU_W-1:0]      out_entries_used
);

  import wcd_pkg::*;

  localparam int AW  = $clog2(MAX_AGENTS);
  localparam int CW  = $clog2(MAX_AGENTS + 1);
  localparam int EW  = 2 + ID_BITS + LEVEL_BITS;
  localparam int ICP = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int LCP = (LEVEL_BITS < WL_W) ? LEVEL_BITS : WL_W;
  localparam int UCP = (CW < EU_W) ? CW : EU_W;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_EXEC  = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  chk_v_r, chk_v_nxt;
  logic [AW-1:0]         chk_idx_r, chk_idx_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [ID_BITS-1:0]    id_r, id_nxt;
  logic                  found_r, found_nxt;
  logic [AW-1:0]         fidx_r, fidx_nxt;
  logic [LEVEL_BITS-1:0] flevel_r, flevel_nxt;
  logic                  fwait_r, fwait_nxt;
  logic                  free_r, free_nxt;
  logic [AW-1:0]         free_idx_r, free_idx_nxt;
  logic                  active_r, active_nxt;
  logic [CW-1:0]         used_r, used_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [WL_W-1:0]       out_level_r, out_level_nxt;
  logic [EU_W-1:0]       out_used_r, out_used_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [EW-1:0]         ram_wdata;
  logic [EW-1:0]         ram_rdata;

  logic                  e_valid, e_wait, e_match;
  logic [ID_BITS-1:0]    e_agent;
  logic [LEVEL_BITS-1:0] e_level;
  logic [ID_BITS-1:0]    id_in;

  logic                  x_we, x_keep;
  logic [AW-1:0]         x_idx;
  logic [LEVEL_BITS-1:0] x_level;
  logic                  x_wait;
  status_t               x_status;
  logic [LEVEL_BITS-1:0] x_out_level;
  logic [CW-1:0]         x_used;

  wcd_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_AGENTS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cnt_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign e_valid = ram_rdata[EW-1];
  assign e_agent = ram_rdata[EW-2 -: ID_BITS];
  assign e_level = ram_rdata[LEVEL_BITS:1];
  assign e_wait  = ram_rdata[0];
  assign e_match = e_valid && (e_agent == id_r);

  always_comb begin
    id_in = '0;
    id_in[ICP-1:0] = in_agent_id[ICP-1:0];
  end

  // entry update for the current request
  always_comb begin
    x_idx       = found_r ? fidx_r : free_idx_r;
    x_level     = found_r ? flevel_r : '0;
    x_wait      = found_r ? fwait_r : 1'b0;
    x_out_level = x_level;
    x_status    = ST_OK;
    x_we        = 1'b0;
    x_keep      = 1'b1;
    x_used      = used_r;
    case (cmd_r)
      CMD_WORK_BEGIN: begin
        if (!found_r && !free_r) begin
          x_status = ST_FULL;
        end else if (x_level == {LEVEL_BITS{1'b1}}) begin
          x_status = ST_OVERFLOW;
        end else begin
          x_level     = x_level + 1'b1;
          x_out_level = x_level;
          x_we        = 1'b1;
          if (!found_r) begin
            x_used = used_r + 1'b1;
          end
        end
      end
      CMD_WORK_END: begin
        if (!found_r) begin
          x_status = ST_NOWORK;
        end else begin
          if (x_level == '0) begin
            x_status = ST_NOWORK;
          end else begin
            x_level = x_level - 1'b1;
          end
          x_out_level = x_level;
          x_we        = 1'b1;
          if (x_level == '0 && !x_wait) begin
            x_keep = 1'b0;
            if (used_r != '0) begin
              x_used = used_r - 1'b1;
            end
          end
        end
      end
      CMD_WAIT_BEGIN: begin
        if (!found_r && !free_r) begin
          x_status = ST_FULL;
        end else if (x_wait) begin
          x_status = ST_WAITMIS;
        end else begin
          x_wait   = 1'b1;
          x_we     = 1'b1;
          x_status = active_r ? ST_OK : ST_CYCLE;
          if (!found_r) begin
            x_used = used_r + 1'b1;
          end
        end
      end
      CMD_WAIT_END: begin
        if (!found_r || !x_wait) begin
          x_status = ST_WAITMIS;
        end else begin
          x_wait = 1'b0;
          x_we   = 1'b1;
          if (x_level == '0) begin
            x_keep = 1'b0;
            if (used_r != '0) begin
              x_used = used_r - 1'b1;
            end
          end
        end
      end
      default: begin
        x_status = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    chk_v_nxt      = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    cmd_nxt        = cmd_r;
    id_nxt         = id_r;
    found_nxt      = found_r;
    fidx_nxt       = fidx_r;
    flevel_nxt     = flevel_r;
    fwait_nxt      = fwait_r;
    free_nxt       = free_r;
    free_idx_nxt   = free_idx_r;
    active_nxt     = active_r;
    used_nxt       = used_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_level_nxt  = out_level_r;
    out_used_nxt   = out_used_r;
    ram_we         = 1'b0;
    ram_waddr      = x_idx;
    ram_wdata      = {x_keep, id_r, x_level, x_wait};
    in_stall       = (state_r != S_IDLE);

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[AW-1:0];
        ram_wdata = '0;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CW'(MAX_AGENTS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = cmd_t'(in_cmd);
          id_nxt     = id_in;
          cnt_nxt    = '0;
          found_nxt  = 1'b0;
          free_nxt   = 1'b0;
          active_nxt = 1'b0;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r < CW'(MAX_AGENTS)) begin
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = cnt_r[AW-1:0];
          cnt_nxt     = cnt_r + 1'b1;
        end else if (!chk_v_r) begin
          state_nxt = S_EXEC;
        end
        if (chk_v_r) begin
          if (e_match && !found_r) begin
            found_nxt  = 1'b1;
            fidx_nxt   = chk_idx_r;
            flevel_nxt = e_level;
            fwait_nxt  = e_wait;
          end
          if (!e_valid && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = chk_idx_r;
          end
          if (e_valid && !e_wait && e_level != '0 && !e_match) begin
            active_nxt = 1'b1;
          end
        end
      end
      S_EXEC: begin
        if (!(out_valid_r && out_stall)) begin
          ram_we         = x_we;
          used_nxt       = x_used;
          out_valid_nxt  = 1'b1;
          out_status_nxt = x_status;
          out_level_nxt  = '0;
          out_level_nxt[LCP-1:0] = x_out_level[LCP-1:0];
          out_used_nxt   = '0;
          out_used_nxt[UCP-1:0]  = x_used[UCP-1:0];
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      chk_v_r     <= 1'b0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      active_r    <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      chk_v_r     <= chk_v_nxt;
      found_r     <= found_nxt;
      free_r      <= free_nxt;
      active_r    <= active_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r    <= chk_idx_nxt;
    cmd_r        <= cmd_nxt;
    id_r         <= id_nxt;
    fidx_r       <= fidx_nxt;
    flevel_r     <= flevel_nxt;
    fwait_r      <= fwait_nxt;
    free_idx_r   <= free_idx_nxt;
    out_status_r <= out_status_nxt;
    out_level_r  <= out_level_nxt;
    out_used_r   <= out_used_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_work_level   = out_level_r;
  assign out_entries_used = out_used_r;

endmodule
